### sv/byte_stack_machine_execute_unit_defines.svh
// Assertion macros for the byte stack machine execute unit.
`ifndef BYTE_STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define BYTE_STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define BSM_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define BSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BSM_ASSERT_ALWAYS(lbl, expr, msg)
`define BSM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### sv/bsm_pkg.sv
// Types and constants shared by the byte stack machine execute unit.
package bsm_pkg;

  localparam int STACK_DEPTH = 4096;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);

  localparam logic [SP_W-1:0] SP_ONE   = SP_W'(1);
  localparam logic [SP_W-1:0] SP_TWO   = SP_W'(2);
  localparam logic [SP_W-1:0] SP_THREE = SP_W'(3);
  localparam logic [SP_W-1:0] SP_FULL  = SP_W'(STACK_DEPTH);

  localparam logic [3:0] OP_CON  = 4'h0;
  localparam logic [3:0] OP_ADD  = 4'h1;
  localparam logic [3:0] OP_SUB  = 4'h2;
  localparam logic [3:0] OP_PUSH = 4'h3;
  localparam logic [3:0] OP_JMP  = 4'hA;
  localparam logic [3:0] OP_PRNT = 4'hB;
  localparam logic [3:0] OP_HALT = 4'hF;

  localparam logic [1:0] ST_RUN     = 2'd0;
  localparam logic [1:0] ST_HALT    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_FAULT   = 2'd3;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [11:0] operand;
  } in_item_t;

  typedef struct packed {
    logic [11:0] next_ip;
    logic        print_valid;
    logic [7:0]  print_byte;
    logic [1:0]  status;
  } out_item_t;

endpackage

### sv/bsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/byte_stack_machine_execute_unit.sv
// Execute stage of a byte stack machine: one instruction in, one result out.
//
// Takes one instruction per clock and returns its result from the output
// register in the cycle after acceptance; a new item is taken whenever that
// register is empty or being drained. The top two stack bytes live in
// registers and the rest in a RAM whose read port always prefetches the
// third byte, so add, subtract, push and print never wait on a RAM read.
// The RAM needs no clearing after reset. After halt, an invalid opcode or a
// stack fault the unit stays stopped until reset and answers every further
// item with the stored status and an unchanged next_ip.
`include "byte_stack_machine_execute_unit_defines.svh"

module byte_stack_machine_execute_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bsm_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bsm_pkg::out_item_t  out_data
);

  logic [bsm_pkg::SP_W-1:0]     sp_r, sp_nxt;
  logic [7:0]                   top_r, top_nxt;
  logic [7:0]                   sec_r, sec_nxt;
  logic [11:0]                  ip_r, ip_nxt;
  logic                         stopped_r, stopped_nxt;
  logic [1:0]                   code_r, code_nxt;
  logic                         fwd_r;
  logic [7:0]                   fwd_byte_r;
  logic                         out_valid_r;
  bsm_pkg::out_item_t           out_data_r;
  bsm_pkg::out_item_t           res;

  logic                         acc;
  logic [7:0]                   third;
  logic                         wr_en;
  logic [bsm_pkg::SP_W-1:0]     sp_wr, sp_rd;
  logic [7:0]                   ram_rdata;

  assign in_ready  = !out_valid_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // third byte from the RAM, or the byte written there last cycle
  assign third = fwd_r ? fwd_byte_r : ram_rdata;
  assign sp_wr = sp_r - bsm_pkg::SP_TWO;
  assign sp_rd = sp_nxt - bsm_pkg::SP_THREE;

  always_comb begin
    logic        stop_now;
    logic [1:0]  stop_code;
    logic [11:0] next;

    sp_nxt      = sp_r;
    top_nxt     = top_r;
    sec_nxt     = sec_r;
    ip_nxt      = ip_r;
    stopped_nxt = stopped_r;
    code_nxt    = code_r;
    wr_en       = 1'b0;
    stop_now    = 1'b0;
    stop_code   = bsm_pkg::ST_RUN;
    next        = ip_r + 12'd1;
    res         = '0;
    res.next_ip = ip_r;
    res.status  = code_r;

    if (acc && !stopped_r) begin
      unique case (in_data.opcode)
        bsm_pkg::OP_CON: begin
        end
        bsm_pkg::OP_ADD, bsm_pkg::OP_SUB: begin
          if (sp_r < bsm_pkg::SP_TWO) begin
            stop_now  = 1'b1;
            stop_code = bsm_pkg::ST_FAULT;
          end else begin
            top_nxt = (in_data.opcode == bsm_pkg::OP_ADD) ? top_r + sec_r : top_r - sec_r;
            sec_nxt = third;
            sp_nxt  = sp_r - bsm_pkg::SP_ONE;
          end
        end
        bsm_pkg::OP_PUSH: begin
          if (sp_r >= bsm_pkg::SP_FULL) begin
            stop_now  = 1'b1;
            stop_code = bsm_pkg::ST_FAULT;
          end else begin
            top_nxt = in_data.operand[7:0];
            sec_nxt = top_r;
            sp_nxt  = sp_r + bsm_pkg::SP_ONE;
            // old second spills to RAM once it becomes the third byte
            wr_en   = (sp_r >= bsm_pkg::SP_TWO);
          end
        end
        bsm_pkg::OP_JMP: begin
          next = in_data.operand;
        end
        bsm_pkg::OP_PRNT: begin
          if (sp_r == '0) begin
            stop_now  = 1'b1;
            stop_code = bsm_pkg::ST_FAULT;
          end else begin
            res.print_valid = 1'b1;
            res.print_byte  = top_r;
            top_nxt         = sec_r;
            sec_nxt         = third;
            sp_nxt          = sp_r - bsm_pkg::SP_ONE;
          end
        end
        bsm_pkg::OP_HALT: begin
          stop_now  = 1'b1;
          stop_code = bsm_pkg::ST_HALT;
        end
        default: begin
          stop_now  = 1'b1;
          stop_code = bsm_pkg::ST_INVALID;
        end
      endcase

      if (stop_now) begin
        stopped_nxt = 1'b1;
        code_nxt    = stop_code;
        res.status  = stop_code;
      end else begin
        ip_nxt      = next;
        res.next_ip = next;
        res.status  = bsm_pkg::ST_RUN;
      end
    end
  end

  bsm_ram #(
    .WIDTH (8),
    .DEPTH (bsm_pkg::STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (sp_wr[bsm_pkg::STACK_AW-1:0]),
    .wdata (sec_r),
    .raddr (sp_rd[bsm_pkg::STACK_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      ip_r        <= '0;
      stopped_r   <= 1'b0;
      code_r      <= bsm_pkg::ST_RUN;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sp_r      <= sp_nxt;
      ip_r      <= ip_nxt;
      stopped_r <= stopped_nxt;
      code_r    <= code_nxt;
      fwd_r     <= wr_en;
      if (in_ready) begin
        out_valid_r <= acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    sec_r      <= sec_nxt;
    fwd_byte_r <= sec_r;
    if (acc) begin
      out_data_r <= res;
    end
  end

  `BSM_ASSERT_ALWAYS(a_sp_range, sp_r <= bsm_pkg::SP_FULL, "stack pointer past depth")
  `BSM_ASSERT_NEXT(a_stop_sticky, stopped_r, stopped_r, "stopped flag cleared")
  `BSM_ASSERT_NEXT(a_stopped_frozen, acc && stopped_r, $stable(sp_r) && $stable(ip_r), "state moved while stopped")
  `BSM_ASSERT_ALWAYS(a_print_running, !(out_valid_r && out_data_r.print_valid) || out_data_r.status == bsm_pkg::ST_RUN, "print with stop status")
  `BSM_ASSERT_ALWAYS(a_fwd_depth, !fwd_r || sp_r >= bsm_pkg::SP_THREE, "forward without third byte")

endmodule

### tb/sv/tb.sv
// Testbench for the byte stack machine execute unit: directed table, random programs, scoreboard.
`timescale 1ns / 100ps

module tb;
  import bsm_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int IGNORED_TAIL = 30;
  localparam logic [SP_W-1:0] FILL_DEPTH = SP_W'(300);

  typedef struct packed {
    in_item_t  instr;
    logic      typed;
    out_item_t want;
  } row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // machine state as the predictor sees it
  logic [7:0]      vm_stack [STACK_DEPTH];
  logic [SP_W-1:0] vm_sp = '0;
  logic [11:0]     vm_ip = '0;
  logic            vm_stopped = 1'b0;
  logic [1:0]      vm_code = ST_RUN;

  out_item_t results_due [$];
  int        fails = 0;
  int        stall_cycles = 0;
  bit        no_idle = 1'b0;
  bit        hold_req = 1'b0;

  byte_stack_machine_execute_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // stack bytes 0xFF,0x01 -> add wraps to 0; jump to 0xFFF then step wraps to 0
  row_t steps [20] = '{
    '{'{OP_CON,  12'h000}, 1'b1, '{12'd1,   1'b0, 8'h00, ST_RUN}},
    '{'{OP_PUSH, 12'hFFF}, 1'b1, '{12'd2,   1'b0, 8'h00, ST_RUN}},
    '{'{OP_PUSH, 12'h001}, 1'b1, '{12'd3,   1'b0, 8'h00, ST_RUN}},
    '{'{OP_ADD,  12'hFFF}, 1'b1, '{12'd4,   1'b0, 8'h00, ST_RUN}},
    '{'{OP_PUSH, 12'hF80}, 1'b0, '0},
    '{'{OP_SUB,  12'h555}, 1'b0, '0},
    '{'{OP_PRNT, 12'hAAA}, 1'b1, '{12'd7,   1'b1, 8'h80, ST_RUN}},
    '{'{OP_JMP,  12'hFFF}, 1'b1, '{12'hFFF, 1'b0, 8'h00, ST_RUN}},
    '{'{OP_CON,  12'hFFF}, 1'b1, '{12'h000, 1'b0, 8'h00, ST_RUN}},
    '{'{OP_PUSH, 12'h0AB}, 1'b0, '0},
    '{'{OP_PUSH, 12'h0CD}, 1'b0, '0},
    '{'{OP_SUB,  12'h000}, 1'b0, '0},
    '{'{OP_PUSH, 12'h7FF}, 1'b0, '0},
    '{'{OP_SUB,  12'h000}, 1'b0, '0},
    '{'{OP_PUSH, 12'h023}, 1'b0, '0},
    '{'{OP_SUB,  12'h000}, 1'b0, '0},
    '{'{OP_PRNT, 12'h000}, 1'b0, '0},
    '{'{OP_JMP,  12'h000}, 1'b1, '{12'h000, 1'b0, 8'h00, ST_RUN}},
    '{'{OP_JMP,  12'h800}, 1'b0, '0},
    '{'{OP_PUSH, 12'h000}, 1'b0, '0}
  };

  function automatic void stop_with(logic [1:0] code);
    vm_stopped = 1'b1;
    vm_code    = code;
  endfunction

  function automatic out_item_t exec_instr(in_item_t instr);
    out_item_t       r;
    logic [11:0]     nxt;
    logic [7:0]      top_b;
    logic [7:0]      sec_b;
    logic [SP_W-1:0] top_i;
    logic [SP_W-1:0] sec_i;
    r = '0;
    top_i = vm_sp - SP_ONE;
    sec_i = vm_sp - SP_TWO;
    if (!vm_stopped) begin
      nxt = vm_ip + 12'd1;
      case (instr.opcode)
        OP_CON: begin
        end
        OP_ADD, OP_SUB: begin
          if (vm_sp < SP_TWO) begin
            stop_with(ST_FAULT);
          end else begin
            top_b = vm_stack[top_i[STACK_AW-1:0]];
            sec_b = vm_stack[sec_i[STACK_AW-1:0]];
            vm_stack[sec_i[STACK_AW-1:0]] = (instr.opcode == OP_ADD) ? top_b + sec_b
                                                                     : top_b - sec_b;
            vm_sp = vm_sp - SP_ONE;
          end
        end
        OP_PUSH: begin
          if (vm_sp == SP_FULL) begin
            stop_with(ST_FAULT);
          end else begin
            vm_stack[vm_sp[STACK_AW-1:0]] = instr.operand[7:0];
            vm_sp = vm_sp + SP_ONE;
          end
        end
        OP_JMP: nxt = instr.operand;
        OP_PRNT: begin
          if (vm_sp < SP_ONE) begin
            stop_with(ST_FAULT);
          end else begin
            r.print_valid = 1'b1;
            r.print_byte  = vm_stack[top_i[STACK_AW-1:0]];
            vm_sp = vm_sp - SP_ONE;
          end
        end
        OP_HALT: stop_with(ST_HALT);
        default: stop_with(ST_INVALID);
      endcase
      if (!vm_stopped) begin
        vm_ip = nxt;
        r.status = ST_RUN;
      end else begin
        r.status = vm_code;
      end
    end else begin
      r.status = vm_code;
    end
    r.next_ip = vm_ip;
    return r;
  endfunction

  function automatic logic [11:0] rand_operand();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 12'h000;
    if (pick == 1) return 12'hFFF;
    return 12'($urandom_range(0, 4095));
  endfunction

  // well-formed instruction for the current stack depth
  function automatic in_item_t pick_running();
    in_item_t it;
    int       roll;
    roll = $urandom_range(0, 99);
    it.operand = rand_operand();
    if (roll < 10)      it.opcode = OP_CON;
    else if (roll < 20) it.opcode = OP_JMP;
    else if (roll < 50) it.opcode = OP_PUSH;
    else if (roll < 65) it.opcode = OP_ADD;
    else if (roll < 80) it.opcode = OP_SUB;
    else                it.opcode = OP_PRNT;
    if (it.opcode == OP_PUSH && vm_sp == SP_FULL) it.opcode = OP_PRNT;
    if ((it.opcode == OP_ADD || it.opcode == OP_SUB) && vm_sp < SP_TWO) it.opcode = OP_PUSH;
    if (it.opcode == OP_PRNT && vm_sp < SP_ONE) it.opcode = OP_PUSH;
    return it;
  endfunction

  task automatic issue(input in_item_t instr, input logic typed, input out_item_t want);
    out_item_t got;
    while (!no_idle && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= instr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = exec_instr(instr);
    results_due.push_back(typed ? want : got);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // result side: random backpressure, one long hold on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= 36);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = results_due.pop_front();
        if (out_data.next_ip !== want.next_ip || out_data.print_valid !== want.print_valid ||
            out_data.print_byte !== want.print_byte || out_data.status !== want.status) begin
          fails++;
          if (fails <= 10)
            $display("mismatch: next_ip %h/%h print_valid %b/%b print_byte %h/%h status %0d/%0d",
                     want.next_ip, out_data.next_ip, want.print_valid, out_data.print_valid,
                     want.print_byte, out_data.print_byte, want.status, out_data.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("FAIL byte_stack_machine_execute_unit");
        $finish;
      end
    end
  end

  initial begin
    in_item_t it;
    int       kind;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (steps[i]) issue(steps[i].instr, steps[i].typed, steps[i].want);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) hold_req = 1'b1;
      if (n == 700) drain_results();
      no_idle = (n >= 800 && n < 1000);
      issue(pick_running(), 1'b0, '0);
    end

    // build a deep stack through the RAM, then empty it
    while (vm_sp < FILL_DEPTH) begin
      it.opcode  = OP_PUSH;
      it.operand = 12'($urandom_range(0, 4095));
      issue(it, 1'b0, '0);
    end
    while (vm_sp != '0) begin
      it = pick_running();
      if (it.opcode == OP_PUSH || it.opcode == OP_CON || it.opcode == OP_JMP) it.opcode = OP_PRNT;
      issue(it, 1'b0, '0);
    end

    // a stop is sticky until reset, so only one kind of stop per run
    kind = $urandom_range(0, 2);
    it.operand = rand_operand();
    case (kind)
      0: it.opcode = OP_HALT;
      1: begin
        do it.opcode = 4'($urandom_range(0, 15));
        while (it.opcode inside {OP_CON, OP_ADD, OP_SUB, OP_PUSH, OP_JMP, OP_PRNT, OP_HALT});
      end
      default: begin
        // underflow: empty stack, or a single byte under add/sub
        if ($urandom_range(0, 1) == 1) begin
          it.opcode = OP_PUSH;
          issue(it, 1'b0, '0);
        end
        if (vm_sp == SP_ONE) it.opcode = ($urandom_range(0, 1) == 1) ? OP_ADD : OP_SUB;
        else begin
          case ($urandom_range(0, 2))
            0:       it.opcode = OP_ADD;
            1:       it.opcode = OP_SUB;
            default: it.opcode = OP_PRNT;
          endcase
        end
      end
    endcase
    issue(it, 1'b0, '0);

    // items after the stop only echo the stored status
    for (int n = 0; n < IGNORED_TAIL; n++) begin
      it.opcode  = 4'($urandom_range(0, 15));
      it.operand = 12'($urandom_range(0, 4095));
      issue(it, 1'b0, '0);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fails == 0 && results_due.size() == 0) begin
      $display("PASS byte_stack_machine_execute_unit");
    end else begin
      $display("FAIL byte_stack_machine_execute_unit");
    end
    $finish;
  end

endmodule
